// ----- src/wdp_pkg.sv -----
// ----------------------------------------------------------------------------
// wdp_pkg: shared definitions for the waveform downscale pool
// Widths, fixed-point constants, register indexes, mode codes and the
// command/status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package wdp_pkg;

    // Field and storage widths.
    localparam int SAMPLE_W    = 16;
    localparam int FACTOR_W    = 16;
    localparam int CORR_SHIFT  = 10;
    localparam int CORR_PROD_W = SAMPLE_W + FACTOR_W + 1;
    localparam int CORR_W      = 24;
    localparam int SUM_W       = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int MEAN_W      = SUM_W + CFG_DATA_W + 1;
    localparam int PRE_W       = 33;
    localparam int VAL_W       = 17;
    localparam int CAL_W       = VAL_W + CFG_DATA_W + 1;
    localparam int DIV_W       = 26;
    localparam int DVSR_W      = 4;
    localparam int POS_W       = 8;
    localparam int WIN_W       = 13;
    localparam int SCNT_W      = 20;
    localparam int OUT_W       = 16;
    localparam int INV_SHIFT   = 16;

    // Saturation limits of the counters.
    localparam int WINDOW_LIMIT = (1 << WIN_W) - 1;
    localparam int SAMPLE_LIMIT = (1 << SCNT_W) - 1;

    // Clamp range in Q.8, rounding terms and the final divisor of ten.
    localparam int CLAMP_LOW     = -12800;
    localparam int CLAMP_HIGH    = 38400;
    localparam int CAL_ROUND     = 20480;
    localparam int CAL_SHIFT     = 12;
    localparam int UNCAL_ROUND   = 5;
    localparam int FINAL_DIVISOR = 10;
    localparam int OUT_MAX       = 32767;
    localparam int OUT_MIN       = -32768;

    // Division by 1, 2, 3 or 10 is a multiply by ceil(2^28 / d) and a shift.
    // The dividend is first raised by d * 2^21 so that it is positive and
    // below 2^25, where the reciprocal gives the exact floor.
    localparam int RECIP_SHIFT = 28;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_BY_1  = 1 << RECIP_SHIFT;
    localparam int RECIP_BY_2  = 1 << (RECIP_SHIFT - 1);
    localparam int RECIP_BY_3  = 89478486;
    localparam int RECIP_BY_10 = 26843546;
    localparam int BIAS_SHIFT  = 21;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_MAX           = 2'd0;
    localparam mode_t MODE_MAX_NEIGHBOUR = 2'd1;
    localparam mode_t MODE_MEAN          = 2'd2;
    localparam mode_t MODE_COPY          = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE          = 3'd0,
        CFG_WINDOW_LENGTH = 3'd1,
        CFG_WINDOW_INV    = 3'd2,
        CFG_WINDOWS       = 3'd3,
        CFG_CAL_ENABLE    = 3'd4,
        CFG_CAL_GAIN      = 3'd5
    } cfg_index_t;

    typedef enum logic {
        DIV_SRC_AVERAGE,
        DIV_SRC_SCALE
    } div_src_t;

    typedef struct packed {
        logic     load_in;
        logic     mul;
        logic     take_right;
        logic     calc_pre;
        logic     div_start;
        div_src_t div_src;
        logic     pre_from_div;
        logic     clamp;
        logic     scale;
        logic     window_upd;
        logic     out_load;
        logic     out_last;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  awaiting;
        logic  emit_copy;
        logic  emit_first;
        logic  window_end;
        logic  take_best;
        logic  window_ok;
        logic  last;
        logic  div_done;
        logic  div_busy;
        logic  out_free;
    } dp_status_t;

endpackage

// ----- src/wdp_div.sv -----
// ----------------------------------------------------------------------------
// wdp_div: reciprocal floor divider
// Divides a signed value by one of the small divisors in use (1, 2, 3 or 10)
// with a reciprocal multiply, rounding toward minus infinity.
// ----------------------------------------------------------------------------
module wdp_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [wdp_pkg::DIV_W-1:0]      dividend,
    input  logic        [wdp_pkg::DVSR_W-1:0]     divisor,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [wdp_pkg::DIV_W-1:0]      quotient
);

    localparam int PROD_W = wdp_pkg::DIV_W + wdp_pkg::RECIP_W;

    logic                          busy_reg;
    logic                          done_reg;
    logic [wdp_pkg::DIV_W-1:0]     num_reg;
    logic [wdp_pkg::RECIP_W-1:0]   recip_reg;
    logic [wdp_pkg::DIV_W-1:0]     quot_reg;

    logic [wdp_pkg::DIV_W-1:0]     offset;
    logic [wdp_pkg::DIV_W-1:0]     num_next;
    logic [wdp_pkg::RECIP_W-1:0]   recip;
    logic [PROD_W-1:0]             prod;

    always_comb
    begin
        case (divisor)
            wdp_pkg::DVSR_W'(2):
                recip = wdp_pkg::RECIP_W'(wdp_pkg::RECIP_BY_2);
            wdp_pkg::DVSR_W'(3):
                recip = wdp_pkg::RECIP_W'(wdp_pkg::RECIP_BY_3);
            wdp_pkg::DVSR_W'(wdp_pkg::FINAL_DIVISOR):
                recip = wdp_pkg::RECIP_W'(wdp_pkg::RECIP_BY_10);
            default:
                recip = wdp_pkg::RECIP_W'(wdp_pkg::RECIP_BY_1);
        endcase
    end

    // Raising the dividend by divisor * 2^21 keeps it positive; the bias
    // comes off the quotient again as a plain 2^21.
    assign offset   = wdp_pkg::DIV_W'(divisor) << wdp_pkg::BIAS_SHIFT;
    assign num_next = $unsigned(dividend) + offset;
    assign prod     = PROD_W'(num_reg) * PROD_W'(recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg   <= num_next;
            recip_reg <= recip;
        end
        else if (busy_reg)
        begin
            quot_reg <= prod[wdp_pkg::RECIP_SHIFT +: wdp_pkg::DIV_W];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = $signed(quot_reg - wdp_pkg::DIV_W'(1 << wdp_pkg::BIAS_SHIFT));

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a run");

endmodule

// ----- src/wdp_datapath.sv -----
// ----------------------------------------------------------------------------
// wdp_datapath: pooling datapath
// Holds the configuration registers, the per-waveform pooling state, the
// scaling registers, the shared divider and the output register.
// ----------------------------------------------------------------------------
module wdp_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [wdp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wdp_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [wdp_pkg::SAMPLE_W-1:0]   sample,
    input  logic [wdp_pkg::FACTOR_W-1:0]          correction_factor,
    input  logic                                  last_sample,
    input  wdp_pkg::dp_cmd_t                      cmd,
    output wdp_pkg::dp_status_t                   status,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [wdp_pkg::OUT_W-1:0]             out_value,
    output logic                                  out_last
);

    // Configuration registers.
    wdp_pkg::mode_t                     mode_reg;
    logic [wdp_pkg::POS_W-1:0]          win_len_reg;
    logic [wdp_pkg::CFG_DATA_W-1:0]     win_inv_reg;
    logic [wdp_pkg::WIN_W-1:0]          wpw_reg;
    logic                               cal_en_reg;
    logic [wdp_pkg::CFG_DATA_W-1:0]     cal_gain_reg;

    // Current item.
    logic signed [wdp_pkg::SAMPLE_W-1:0] sample_reg;
    logic [wdp_pkg::FACTOR_W-1:0]        factor_reg;
    logic                                last_reg;
    logic signed [wdp_pkg::CORR_W-1:0]   c_reg;

    // Pooling state.
    logic signed [wdp_pkg::CORR_W-1:0]   best_reg;
    logic signed [wdp_pkg::SUM_W-1:0]    sum_reg;
    logic signed [wdp_pkg::CORR_W-1:0]   left_reg;
    logic signed [wdp_pkg::CORR_W-1:0]   prev_reg;
    logic [1:0]                          cnt_reg;
    logic [wdp_pkg::POS_W-1:0]           pos_reg;
    logic [wdp_pkg::WIN_W-1:0]           win_cnt_reg;
    logic                                await_reg;
    logic [wdp_pkg::SCNT_W-1:0]          smp_cnt_reg;

    // Result chain.
    logic signed [wdp_pkg::PRE_W-1:0]    pre_reg;
    logic signed [wdp_pkg::VAL_W-1:0]    v_reg;
    logic signed [wdp_pkg::DIV_W-1:0]    x_reg;

    logic                                out_valid_reg;
    logic [wdp_pkg::OUT_W-1:0]           out_value_reg;
    logic                                out_last_reg;

    logic signed [wdp_pkg::CORR_PROD_W-1:0] corr_prod;
    logic signed [wdp_pkg::MEAN_W-1:0]      mean_prod;
    logic signed [wdp_pkg::CAL_W-1:0]       cal_prod;
    logic signed [wdp_pkg::CAL_W-1:0]       cal_sum;
    logic signed [wdp_pkg::DIV_W-1:0]       avg_sum;
    logic [wdp_pkg::POS_W-1:0]              len_eff;
    logic                                   window_end;
    logic                                   take_best;
    logic                                   is_copy;

    logic                                   div_start;
    logic signed [wdp_pkg::DIV_W-1:0]       div_dividend;
    logic [wdp_pkg::DVSR_W-1:0]             div_divisor;
    logic                                   div_busy;
    logic                                   div_done;
    logic signed [wdp_pkg::DIV_W-1:0]       div_quotient;
    logic [wdp_pkg::OUT_W-1:0]              sat_value;

    assign corr_prod = sample_reg * $signed({1'b0, factor_reg});
    assign mean_prod = sum_reg * $signed({1'b0, win_inv_reg});
    assign cal_prod  = v_reg * $signed({1'b0, cal_gain_reg});
    assign cal_sum   = cal_prod + wdp_pkg::CAL_W'(wdp_pkg::CAL_ROUND);
    assign avg_sum   = wdp_pkg::DIV_W'(best_reg) + wdp_pkg::DIV_W'(left_reg);
    assign is_copy   = (mode_reg == wdp_pkg::MODE_COPY);

    // A zero window length behaves as a length of one.
    assign len_eff    = (win_len_reg == '0) ? wdp_pkg::POS_W'(1) : win_len_reg;
    assign window_end = (({1'b0, pos_reg} + (wdp_pkg::POS_W+1)'(1)) >= {1'b0, len_eff});
    assign take_best  = (pos_reg == '0) || (c_reg > best_reg);

    always_comb
    begin
        status            = '0;
        status.mode       = mode_reg;
        status.awaiting   = await_reg;
        status.emit_copy  = (smp_cnt_reg < wdp_pkg::SCNT_W'(wpw_reg));
        status.emit_first = (pos_reg == '0) && (win_cnt_reg != '0)
                            && ((win_cnt_reg - wdp_pkg::WIN_W'(1)) < wpw_reg);
        status.window_end = window_end;
        status.take_best  = take_best;
        status.window_ok  = (win_cnt_reg < wpw_reg);
        status.last       = last_reg;
        status.div_done   = div_done;
        status.div_busy   = div_busy;
        status.out_free   = !out_valid_reg || out_ready;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= wdp_pkg::MODE_MAX;
            win_len_reg  <= wdp_pkg::POS_W'(10);
            win_inv_reg  <= wdp_pkg::CFG_DATA_W'(6554);
            wpw_reg      <= wdp_pkg::WIN_W'(600);
            cal_en_reg   <= 1'b0;
            cal_gain_reg <= wdp_pkg::CFG_DATA_W'(4096);
        end
        else if (cfg_we)
        begin
            unique case (wdp_pkg::cfg_index_t'(cfg_index))
                wdp_pkg::CFG_MODE:          mode_reg     <= cfg_data[1:0];
                wdp_pkg::CFG_WINDOW_LENGTH: win_len_reg  <= cfg_data[wdp_pkg::POS_W-1:0];
                wdp_pkg::CFG_WINDOW_INV:    win_inv_reg  <= cfg_data;
                wdp_pkg::CFG_WINDOWS:       wpw_reg      <= cfg_data[wdp_pkg::WIN_W-1:0];
                wdp_pkg::CFG_CAL_ENABLE:    cal_en_reg   <= cfg_data[0];
                wdp_pkg::CFG_CAL_GAIN:      cal_gain_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Pooling state. Later commands never share a cycle with earlier ones.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg    <= '0;
            sum_reg     <= '0;
            left_reg    <= '0;
            prev_reg    <= '0;
            cnt_reg     <= 2'd1;
            pos_reg     <= '0;
            win_cnt_reg <= '0;
            await_reg   <= 1'b0;
            smp_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.take_right)
            begin
                left_reg  <= left_reg + c_reg;
                cnt_reg   <= cnt_reg + 2'd1;
                await_reg <= 1'b0;
            end
            if (cmd.window_upd)
            begin
                if (pos_reg == '0)
                begin
                    sum_reg <= wdp_pkg::SUM_W'(c_reg);
                end
                else
                begin
                    sum_reg <= sum_reg + wdp_pkg::SUM_W'(c_reg);
                end
                if (take_best)
                begin
                    best_reg <= c_reg;
                    // The first sample of a waveform has no left neighbour.
                    if (smp_cnt_reg != '0)
                    begin
                        left_reg <= prev_reg;
                        cnt_reg  <= 2'd2;
                    end
                    else
                    begin
                        left_reg <= '0;
                        cnt_reg  <= 2'd1;
                    end
                end
                if (window_end)
                begin
                    pos_reg <= '0;
                    if (win_cnt_reg != wdp_pkg::WIN_W'(wdp_pkg::WINDOW_LIMIT))
                    begin
                        win_cnt_reg <= win_cnt_reg + wdp_pkg::WIN_W'(1);
                    end
                end
                else
                begin
                    pos_reg <= pos_reg + wdp_pkg::POS_W'(1);
                end
                await_reg <= (mode_reg == wdp_pkg::MODE_MAX_NEIGHBOUR) && take_best;
            end
            if (cmd.finish)
            begin
                if (last_reg)
                begin
                    best_reg    <= '0;
                    sum_reg     <= '0;
                    left_reg    <= '0;
                    prev_reg    <= '0;
                    cnt_reg     <= 2'd1;
                    pos_reg     <= '0;
                    win_cnt_reg <= '0;
                    await_reg   <= 1'b0;
                    smp_cnt_reg <= '0;
                end
                else
                begin
                    prev_reg <= c_reg;
                    if (smp_cnt_reg != wdp_pkg::SCNT_W'(wdp_pkg::SAMPLE_LIMIT))
                    begin
                        smp_cnt_reg <= smp_cnt_reg + wdp_pkg::SCNT_W'(1);
                    end
                    if (is_copy)
                    begin
                        await_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // Item and result chain registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg <= sample;
            factor_reg <= correction_factor;
            last_reg   <= last_sample;
        end
        if (cmd.mul)
        begin
            c_reg <= wdp_pkg::CORR_W'(corr_prod >>> wdp_pkg::CORR_SHIFT);
        end
        if (cmd.calc_pre)
        begin
            if (mode_reg == wdp_pkg::MODE_MEAN)
            begin
                pre_reg <= wdp_pkg::PRE_W'(mean_prod >>> wdp_pkg::INV_SHIFT);
            end
            else
            begin
                pre_reg <= wdp_pkg::PRE_W'(best_reg);
            end
        end
        else if (cmd.pre_from_div)
        begin
            pre_reg <= wdp_pkg::PRE_W'(div_quotient);
        end
        if (cmd.clamp)
        begin
            if (pre_reg < wdp_pkg::PRE_W'(wdp_pkg::CLAMP_LOW))
            begin
                v_reg <= wdp_pkg::VAL_W'(wdp_pkg::CLAMP_LOW);
            end
            else if (pre_reg > wdp_pkg::PRE_W'(wdp_pkg::CLAMP_HIGH))
            begin
                v_reg <= wdp_pkg::VAL_W'(wdp_pkg::CLAMP_HIGH);
            end
            else
            begin
                v_reg <= wdp_pkg::VAL_W'(pre_reg);
            end
        end
        if (cmd.scale)
        begin
            if (cal_en_reg)
            begin
                x_reg <= wdp_pkg::DIV_W'(cal_sum >>> wdp_pkg::CAL_SHIFT);
            end
            else
            begin
                x_reg <= wdp_pkg::DIV_W'(v_reg) + wdp_pkg::DIV_W'(wdp_pkg::UNCAL_ROUND);
            end
        end
        if (cmd.out_load)
        begin
            out_value_reg <= is_copy ? sample_reg : sat_value;
            out_last_reg  <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The divider serves the neighbour average and the final division by ten.
    assign div_start    = cmd.div_start;
    assign div_dividend = (cmd.div_src == wdp_pkg::DIV_SRC_AVERAGE) ? avg_sum : x_reg;
    assign div_divisor  = (cmd.div_src == wdp_pkg::DIV_SRC_AVERAGE)
                          ? {2'b00, cnt_reg}
                          : wdp_pkg::DVSR_W'(wdp_pkg::FINAL_DIVISOR);

    wdp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        if (div_quotient > wdp_pkg::DIV_W'(wdp_pkg::OUT_MAX))
        begin
            sat_value = wdp_pkg::OUT_W'(wdp_pkg::OUT_MAX);
        end
        else if (div_quotient < wdp_pkg::DIV_W'(wdp_pkg::OUT_MIN))
        begin
            sat_value = wdp_pkg::OUT_W'(wdp_pkg::OUT_MIN);
        end
        else
        begin
            sat_value = div_quotient[wdp_pkg::OUT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

    a_await_count: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> (cnt_reg != 2'd3))
        else $error("pending right neighbour with a full neighbour count");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten before its beat was taken");

endmodule

// ----- src/wdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// wdp_ctrl: pooling controller
// Steps one sample through multiply, neighbour update, window update and up to
// two result computations, or a copy, and hands each to the output register.
// ----------------------------------------------------------------------------
module wdp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wdp_pkg::dp_status_t   status,
    output wdp_pkg::dp_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DECIDE,
        ST_PRE,
        ST_DIV_A,
        ST_CLAMP,
        ST_SCALE,
        ST_DIV_B_GO,
        ST_DIV_B,
        ST_EMIT,
        ST_WINDOW,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   second_reg;
    logic   second_next;
    logic   emit2_reg;
    logic   emit2_next;
    logic   is_neighbour;

    assign is_neighbour = (status.mode == wdp_pkg::MODE_MAX_NEIGHBOUR);

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        emit2_next  = emit2_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (status.mode == wdp_pkg::MODE_COPY)
                begin
                    second_next = 1'b1;
                    emit2_next  = 1'b0;
                    state_next  = status.emit_copy ? ST_EMIT : ST_FINISH;
                end
                else
                begin
                    // The window-end result is held back in neighbour mode
                    // while the maximum still waits for its right neighbour.
                    emit2_next = status.window_end && status.window_ok
                                 && !(is_neighbour && status.take_best && !status.last);
                    state_next = ST_WINDOW;
                    if (is_neighbour && status.awaiting)
                    begin
                        cmd.take_right = 1'b1;
                        if (status.emit_first)
                        begin
                            second_next = 1'b0;
                            state_next  = ST_PRE;
                        end
                    end
                end
            end
            ST_PRE:
            begin
                if (is_neighbour)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = wdp_pkg::DIV_SRC_AVERAGE;
                    state_next    = ST_DIV_A;
                end
                else
                begin
                    cmd.calc_pre = 1'b1;
                    state_next   = ST_CLAMP;
                end
            end
            ST_DIV_A:
            begin
                cmd.div_src = wdp_pkg::DIV_SRC_AVERAGE;
                if (status.div_done)
                begin
                    cmd.pre_from_div = 1'b1;
                    state_next       = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DIV_B_GO;
            end
            ST_DIV_B_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = wdp_pkg::DIV_SRC_SCALE;
                state_next    = ST_DIV_B;
            end
            ST_DIV_B:
            begin
                cmd.div_src = wdp_pkg::DIV_SRC_SCALE;
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = status.last && (second_reg || !emit2_reg);
                    state_next   = second_reg ? ST_FINISH : ST_WINDOW;
                end
            end
            ST_WINDOW:
            begin
                cmd.window_upd = 1'b1;
                if (emit2_reg)
                begin
                    second_next = 1'b1;
                    state_next  = ST_PRE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            second_reg <= 1'b0;
            emit2_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            emit2_reg  <= emit2_next;
        end
    end

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !status.div_busy)
        else $error("divider still running between samples");

endmodule

// ----- src/waveform_downscale_pool.sv -----
// ----------------------------------------------------------------------------
// waveform_downscale_pool: decimating max / max-mean / mean pooling
// Corrects each waveform sample by its factor, pools the products per window
// and emits clamped, scaled Q8.8 window results, or copies the raw samples.
//
//   Port group    Dir   Payload
//   s_*           in    tdata: sample, correction_factor; tlast: last_sample
//   m_*           out   tdata: value; tlast: last_result
//   cfg_*         in    write enable, register index, write data
//
// A sample without a result passes the multiply, decide, window and finish
// steps; in copy mode a copied sample passes the emit step in place of the
// window step, a dropped sample neither. A window result adds the pre, clamp,
// scale and reciprocal divider steps, and in neighbour mode a divider run for
// the average; a neighbour-mode step may give two results. A stalled output holds
// the controller in its emit step once the output register is full. Reset clears
// configuration to its defaults and the pooling state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module waveform_downscale_pool (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // [15:0] sample, [31:16] correction_factor
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // [15:0] value
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [wdp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wdp_pkg::CFG_DATA_W-1:0]     cfg_data
);

    wdp_pkg::dp_cmd_t    cmd;
    wdp_pkg::dp_status_t status;

    wdp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wdp_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .sample            ($signed(s_tdata[15:0])),
        .correction_factor (s_tdata[31:16]),
        .last_sample       (s_tlast),
        .cmd               (cmd),
        .status            (status),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .out_value         (m_tdata),
        .out_last          (m_tlast)
    );

endmodule

// ----- tb/waveform_downscale_pool_tb.sv -----
// ----------------------------------------------------------------------------
// waveform_downscale_pool_tb: self-checking bench for the waveform pool
// Streams waveform samples with their correction factors into the block and
// holds its own model of the pooling, clamping and scaling. Every output beat
// is compared with the oldest predicted result. A short directed
// sequence comes first, then random waveforms under random register settings,
// with random gaps on both stream sides for the first 740 beats sent.
// ----------------------------------------------------------------------------
module waveform_downscale_pool_tb;
    import wdp_pkg::*;

    typedef struct {
        logic signed [15:0] sample;
        logic [15:0]        factor;
        logic               last;
    } wave_beat_t;

    typedef struct {
        logic [15:0] value;
        logic        last;
    } pool_out_t;

    localparam int TARGET_BEATS = 1100;
    localparam int SETTLE_CYCLES = 200;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [15:0] sample, [31:16] correction_factor
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [15:0] value
    logic        m_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wave_beat_t sample_backlog[$];
    pool_out_t  expected_pool_out[$];
    wave_beat_t next_beat;
    pool_out_t  want;
    logic       in_beat_taken = 1'b0;
    int         beats_queued = 0;
    int         beats_sent = 0;
    int         send_idle_pct = 9;
    int         recv_idle_pct = 50;
    int         mismatch_count = 0;

    // Register copies, at their reset values.
    mode_t cfg_mode = MODE_MAX;
    int    cfg_len = 10;
    int    cfg_inv = 6554;
    int    cfg_windows = 600;
    bit    cfg_cal_en = 1'b0;
    int    cfg_gain = 4096;

    // Pooling state of the waveform in progress.
    longint pool_best, pool_sum, nbr_sum, prev_corr;
    int     nbr_count, win_pos, win_count, seen_count;
    bit     right_pending;

    waveform_downscale_pool DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint floor_div(input longint a, input longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q--;
        return q;
    endfunction

    function automatic logic [15:0] scale_to_q88(input longint v);
        longint r;
        if (v < CLAMP_LOW)
            v = CLAMP_LOW;
        if (v > CLAMP_HIGH)
            v = CLAMP_HIGH;
        if (cfg_cal_en)
            r = floor_div(v * longint'(cfg_gain) + CAL_ROUND, 40960);
        else
            r = floor_div(v + UNCAL_ROUND, FINAL_DIVISOR);
        if (r > OUT_MAX)
            r = OUT_MAX;
        if (r < OUT_MIN)
            r = OUT_MIN;
        return r[15:0];
    endfunction

    function automatic logic [15:0] window_value();
        if (cfg_mode == MODE_MAX_NEIGHBOUR)
            return scale_to_q88(floor_div(pool_best + nbr_sum, longint'(nbr_count)));
        if (cfg_mode == MODE_MEAN)
            return scale_to_q88(floor_div(pool_sum * longint'(cfg_inv), 65536));
        return scale_to_q88(pool_best);
    endfunction

    task automatic clear_waveform();
        pool_best = 0;
        pool_sum = 0;
        nbr_sum = 0;
        prev_corr = 0;
        nbr_count = 1;
        win_pos = 0;
        win_count = 0;
        right_pending = 1'b0;
        seen_count = 0;
    endtask

    task automatic take_as_peak(input longint c);
        pool_best = c;
        if (seen_count > 0)
        begin
            nbr_sum = prev_corr;
            nbr_count = 2;
        end
        else
        begin
            nbr_sum = 0;
            nbr_count = 1;
        end
        right_pending = 1'b1;
    endtask

    // Advances the pooling model by one sample and queues the window results
    // that it releases.
    task automatic pool_step(input logic signed [15:0] smp, input logic [15:0] fac,
                             input logic last);
        longint      sv, fv, c;
        int          len, idx, n, i;
        logic [15:0] vals[2];
        pool_out_t   res;
        sv = smp;
        fv = fac;
        c = floor_div(sv * fv, longint'(1) << CORR_SHIFT);
        len = (cfg_len == 0) ? 1 : cfg_len;
        n = 0;
        if (cfg_mode == MODE_COPY)
        begin
            right_pending = 1'b0;
            if (seen_count < cfg_windows)
            begin
                vals[n] = smp;
                n++;
            end
        end
        else
        begin
            if (cfg_mode != MODE_MAX_NEIGHBOUR)
                right_pending = 1'b0;
            if (right_pending)
            begin
                nbr_sum += c;
                nbr_count++;
                right_pending = 1'b0;
                // The held window closed on the previous sample.
                if (win_pos == 0 && win_count > 0 && win_count - 1 < cfg_windows)
                begin
                    vals[n] = window_value();
                    n++;
                end
            end
            if (win_pos == 0)
            begin
                pool_sum = c;
                take_as_peak(c);
            end
            else
            begin
                pool_sum += c;
                if (c > pool_best)
                    take_as_peak(c);
            end
            if (cfg_mode != MODE_MAX_NEIGHBOUR)
                right_pending = 1'b0;
            win_pos++;
            if (win_pos >= len)
            begin
                idx = win_count;
                win_pos = 0;
                if (win_count < WINDOW_LIMIT)
                    win_count++;
                if (!(cfg_mode == MODE_MAX_NEIGHBOUR && right_pending && !last))
                begin
                    right_pending = 1'b0;
                    if (idx < cfg_windows)
                    begin
                        vals[n] = window_value();
                        n++;
                    end
                end
            end
        end
        prev_corr = c;
        if (seen_count < SAMPLE_LIMIT)
            seen_count++;
        for (i = 0; i < n; i++)
        begin
            res.value = vals[i];
            res.last = last && (i == n - 1);
            expected_pool_out.push_back(res);
        end
        if (last)
            clear_waveform();
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < 100)
            $display("ERROR at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Input side: a new beat goes out once the previous one has been taken.
    always @(negedge clk)
    begin
        if (beats_sent < 370)
        begin
            send_idle_pct = 9;
            recv_idle_pct = 50;
        end
        else if (beats_sent < 740)
        begin
            send_idle_pct = 50;
            recv_idle_pct = 9;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (rst_n && (!s_tvalid || in_beat_taken))
        begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_beat = sample_backlog.pop_front();
                beats_sent++;
                s_tdata <= {next_beat.factor, next_beat.sample};
                s_tlast <= next_beat.last;
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        in_beat_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
            pool_step(s_tdata[15:0], s_tdata[31:16], s_tlast);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pool_out.size() == 0)
                report_mismatch($sformatf("unexpected result beat value %h", m_tdata));
            else
            begin
                want = expected_pool_out.pop_front();
                if (m_tdata !== want.value)
                    report_mismatch($sformatf("value %h, expected %h", m_tdata, want.value));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("tlast %b, expected %b", m_tlast, want.last));
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_MODE:          cfg_mode = data[1:0];
            CFG_WINDOW_LENGTH: cfg_len = data[7:0];
            CFG_WINDOW_INV:    cfg_inv = data;
            CFG_WINDOWS:       cfg_windows = data[12:0];
            CFG_CAL_ENABLE:    cfg_cal_en = data[0];
            CFG_CAL_GAIN:      cfg_gain = data;
            default:           ;
        endcase
    endtask

    task automatic program_regs(input mode_t m, input int len, input int inv,
                                input int windows, input bit cal, input int gain);
        write_reg(CFG_MODE, 16'(m));
        write_reg(CFG_WINDOW_LENGTH, 16'(len));
        write_reg(CFG_WINDOW_INV, 16'(inv));
        write_reg(CFG_WINDOWS, 16'(windows));
        write_reg(CFG_CAL_ENABLE, 16'(cal));
        write_reg(CFG_CAL_GAIN, 16'(gain));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_beat(input logic signed [15:0] s, input logic [15:0] f,
                              input logic last);
        wave_beat_t b;
        b.sample = s;
        b.factor = f;
        b.last = last;
        sample_backlog.push_back(b);
        beats_queued++;
    endtask

    // Waits until every beat is out and every result is in; a sample with no
    // result may still be in flight, hence the extra cycles.
    task automatic settle();
        while (sample_backlog.size() != 0 || s_tvalid || expected_pool_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        int v;
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        v = $urandom_range(6000);
        return 16'(v - 3000);
    endfunction

    function automatic logic [15:0] rand_factor();
        if ($urandom_range(3) == 0)
            return 16'($urandom);
        return 16'($urandom_range(24576, 8192));
    endfunction

    // Repeated beats now and then give ties for the window maximum.
    task automatic queue_waveform(input int count, input bit close);
        int                 i;
        logic signed [15:0] s;
        logic [15:0]        f;
        s = 0;
        f = 16384;
        for (i = 0; i < count; i++)
        begin
            if (i == 0 || $urandom_range(7) != 0)
            begin
                s = rand_sample();
                f = rand_factor();
            end
            queue_beat(s, f, close && (i == count - 1));
        end
    endtask

    task automatic run_random_phase();
        mode_t m;
        int    len, eff, inv, wins, gain, waves, w, count, r;
        bit    cal;
        m = mode_t'($urandom_range(3));
        r = $urandom_range(19);
        // Long windows only while there is room left in the item budget.
        if (r == 0 && beats_queued + 255 < TARGET_BEATS)
            len = 255;
        else if (r == 1)
            len = 0;
        else
            len = $urandom_range(8, 1);
        eff = (len == 0) ? 1 : len;
        r = $urandom_range(9);
        if (r == 0)
            inv = 0;
        else if (r == 1)
            inv = 65535;
        else if (r == 2)
            inv = $urandom_range(65535);
        else
            inv = (65536 + eff / 2) / eff;
        if (inv > 65535)
            inv = 65535;
        r = $urandom_range(9);
        if (r == 0)
            wins = 4096;
        else if (r == 1)
            wins = 0;
        else
            wins = $urandom_range(6, 1);
        cal = 1'($urandom_range(1));
        r = $urandom_range(9);
        if (r == 0)
            gain = 0;
        else if (r == 1)
            gain = 65535;
        else
            gain = $urandom_range(8192, 2048);
        program_regs(m, len, inv, wins, cal, gain);
        waves = (eff == 255) ? 1 : $urandom_range(4, 1);
        for (w = 0; w < waves; w++)
        begin
            if (m == MODE_COPY)
                count = $urandom_range(10, 1);
            else
            begin
                count = eff * ((eff == 255) ? 1 : $urandom_range(7));
                if ($urandom_range(1) != 0)
                    count += $urandom_range(eff);
                if (count == 0)
                    count = 1;
            end
            // Sometimes the waveform stays open so the next setting inherits it.
            queue_waveform(count, !(w == waves - 1 && $urandom_range(4) == 0));
        end
        settle();
    endtask

    initial
    begin
        clear_waveform();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Neighbour mode: a tie, a peak at a window end whose right neighbour
        // opens a window past the count, a last beat with no result, a peak at
        // the end of the waveform, and an incomplete final window.
        program_regs(MODE_MAX_NEIGHBOUR, 3, 21845, 2, 1'b0, 4096);
        queue_beat(100, 16384, 1'b0);
        queue_beat(300, 16384, 1'b0);
        queue_beat(300, 16384, 1'b0);
        queue_beat(-32768, 65535, 1'b0);
        queue_beat(0, 0, 1'b0);
        queue_beat(32767, 65535, 1'b0);
        queue_beat(100, 16384, 1'b0);
        queue_beat(200, 16384, 1'b0);
        queue_beat(7, 16384, 1'b1);
        queue_beat(10, 16384, 1'b0);
        queue_beat(20, 16384, 1'b0);
        queue_beat(30, 16384, 1'b1);
        queue_beat(5, 16384, 1'b0);
        queue_beat(6, 16384, 1'b1);
        settle();

        // Mean with zero window length and full calibration gain.
        program_regs(MODE_MEAN, 0, 65535, 4096, 1'b1, 65535);
        queue_beat(32767, 65535, 1'b0);
        queue_beat(-32768, 65535, 1'b0);
        queue_beat(-1, 1, 1'b1);
        settle();

        // Zero window count: nothing comes out.
        program_regs(MODE_MAX, 1, 65535, 0, 1'b0, 0);
        queue_beat(1000, 16384, 1'b0);
        queue_beat(2000, 16384, 1'b1);
        settle();

        // Copy mode, with samples past the count dropped.
        program_regs(MODE_COPY, 255, 257, 2, 1'b0, 4096);
        queue_beat(-32768, 0, 1'b0);
        queue_beat(32767, 65535, 1'b0);
        queue_beat(1, 1, 1'b1);
        settle();

        // Mode change inside a waveform while a right neighbour is pending.
        program_regs(MODE_MAX_NEIGHBOUR, 2, 32768, 4096, 1'b0, 4096);
        queue_beat(1, 16384, 1'b0);
        queue_beat(50, 16384, 1'b0);
        settle();
        program_regs(MODE_MAX, 2, 32768, 4096, 1'b0, 4096);
        queue_beat(3, 16384, 1'b0);
        queue_beat(4, 16384, 1'b1);
        settle();

        while (beats_queued < TARGET_BEATS)
            run_random_phase();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
